>>> design/mte_pkg.sv
package mte_pkg;

	localparam int TimeW     = 32;
	localparam int DigitW    = 7;
	localparam int NumDigits = 5;
	localparam int DeltaW    = DigitW * NumDigits;
	// bits of the top group that fall inside the 32-bit delta
	localparam int TopBits   = TimeW - DigitW * (NumDigits - 1);
	localparam int CntW      = 3;

	localparam logic [3:0] TYPE_PROGRAM_CHANGE = 4'hC;
	localparam logic [7:0] CONT_BIT            = 8'h80;
	localparam logic [7:0] EOT_META            = 8'hFF;
	localparam logic [7:0] EOT_TYPE            = 8'h2F;
	localparam logic [7:0] EOT_LEN             = 8'h00;
	localparam logic [7:0] EOT_DELTA           = 8'h00;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WAIT,
		ST_DELTA,
		ST_STATUS,
		ST_DATA1,
		ST_DATA2,
		ST_EOT
	} enc_state_t;

	typedef struct packed {
		logic            done;
		logic [CntW-1:0] groups;
	} dstat_t;

	function automatic logic [7:0] eot_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0:    b = EOT_DELTA;
			2'd1:    b = EOT_META;
			2'd2:    b = EOT_TYPE;
			default: b = EOT_LEN;
		endcase
		return b;
	endfunction

endpackage

>>> design/mte_if.sv
interface mte_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [31:0] event_time;
	logic [3:0]  message_type;
	logic [3:0]  channel;
	logic [6:0]  first_data;
	logic [6:0]  second_data;

	modport source(output valid, action, event_time, message_type, channel, first_data,
		second_data, input ready);
	modport sink(input valid, action, event_time, message_type, channel, first_data,
		second_data, output ready);
endinterface

interface mte_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_byte;

	modport source(output valid, out_byte, last_byte, input ready);
	modport sink(input valid, out_byte, last_byte, output ready);
endinterface

>>> design/midi_track_event_encoder_core.sv
// channel | dir | payload                                              | handshake
// evt     | in  | action, event_time, message_type, channel, data x2   | valid/ready
// trk     | out | out_byte, last_byte                                  | valid/ready
//
// one item at a time: a channel event is accepted, its delta is reckoned in the
// digit-serial subtractor (one 7-bit group a cycle) and handed off, then it is
// sent as 3 to 8 bytes; end of track sends 4 bytes.
// arst_n clears the controller, the output valid and the stored time to 0.
// a stall on trk holds the byte in the output register and freezes the sequencer while it has a byte to send.
module midi_track_event_encoder_core (
	input  logic       clk,
	input  logic       arst_n,
	mte_in_if.sink     evt,
	mte_out_if.source  trk
);

	mte_pkg::enc_state_t state_q, state_d;

	logic [mte_pkg::TimeW-1:0]  prev_time_q;
	logic [3:0]                 type_q, chan_q;
	logic [6:0]                 d1_q, d2_q;
	logic [mte_pkg::CntW-1:0]   grp_q, grp_d;
	logic [1:0]                 eot_q, eot_d;
	logic [7:0]                 ob_q;
	logic                       ol_q, ov_q;

	logic                       accept, start, can_emit, emit, emit_last;
	logic [7:0]                 emit_byte;
	logic [mte_pkg::DeltaW-1:0] delta;
	mte_pkg::dstat_t            dstat;
	logic [mte_pkg::DigitW-1:0] digit;

	mte_delta_sub u_sub (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cur_time  (evt.event_time),
		.prev_time (prev_time_q),
		.delta     (delta),
		.stat      (dstat)
	);

	assign accept   = evt.valid && evt.ready;
	assign start    = accept && !evt.action;
	assign can_emit = !ov_q || trk.ready;

	always_comb begin
		case (grp_q)
			3'd0:    digit = delta[0 +: mte_pkg::DigitW];
			3'd1:    digit = delta[mte_pkg::DigitW +: mte_pkg::DigitW];
			3'd2:    digit = delta[2*mte_pkg::DigitW +: mte_pkg::DigitW];
			3'd3:    digit = delta[3*mte_pkg::DigitW +: mte_pkg::DigitW];
			default: digit = delta[4*mte_pkg::DigitW +: mte_pkg::DigitW];
		endcase
	end

	always_comb begin
		state_d   = state_q;
		grp_d     = grp_q;
		eot_d     = eot_q;
		emit      = 1'b0;
		emit_last = 1'b0;
		emit_byte = '0;
		evt.ready = 1'b0;
		case (state_q)
			mte_pkg::ST_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid) begin
					eot_d   = '0;
					state_d = evt.action ? mte_pkg::ST_EOT : mte_pkg::ST_WAIT;
				end
			end
			mte_pkg::ST_WAIT: begin
				if (dstat.done) begin
					grp_d   = dstat.groups - mte_pkg::CntW'(1);
					state_d = mte_pkg::ST_DELTA;
				end
			end
			mte_pkg::ST_DELTA: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = {1'b0, digit} | ((grp_q != '0) ? mte_pkg::CONT_BIT : 8'h00);
					if (grp_q == '0) begin
						state_d = mte_pkg::ST_STATUS;
					end else begin
						grp_d = grp_q - mte_pkg::CntW'(1);
					end
				end
			end
			mte_pkg::ST_STATUS: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = {type_q, chan_q};
					state_d   = mte_pkg::ST_DATA1;
				end
			end
			mte_pkg::ST_DATA1: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = {1'b0, d1_q};
					emit_last = (type_q == mte_pkg::TYPE_PROGRAM_CHANGE);
					state_d   = emit_last ? mte_pkg::ST_IDLE : mte_pkg::ST_DATA2;
				end
			end
			mte_pkg::ST_DATA2: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = {1'b0, d2_q};
					emit_last = 1'b1;
					state_d   = mte_pkg::ST_IDLE;
				end
			end
			mte_pkg::ST_EOT: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_byte = mte_pkg::eot_byte(eot_q);
					emit_last = (eot_q == 2'd3);
					eot_d     = eot_q + 2'd1;
					if (emit_last) begin
						state_d = mte_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = mte_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mte_pkg::ST_IDLE;
			grp_q       <= '0;
			eot_q       <= '0;
			prev_time_q <= '0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			grp_q   <= grp_d;
			eot_q   <= eot_d;
			if (accept) begin
				prev_time_q <= evt.action ? '0 : evt.event_time;
			end
			if (emit) begin
				ov_q <= 1'b1;
			end else if (trk.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			type_q <= evt.message_type;
			chan_q <= evt.channel;
			d1_q   <= evt.first_data;
			d2_q   <= evt.second_data;
		end
		if (emit) begin
			ob_q <= emit_byte;
			ol_q <= emit_last;
		end
	end

	assign trk.valid     = ov_q;
	assign trk.out_byte  = ob_q;
	assign trk.last_byte = ol_q;

	a_start_wait: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> (state_q == mte_pkg::ST_WAIT))
		else $error("channel event transfer did not start the subtractor");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(emit && ov_q && !trk.ready))
		else $error("output byte overwritten while stalled");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && emit_last) |=> (state_q == mte_pkg::ST_IDLE))
		else $error("sequencer did not return to idle after last byte");
	a_grp_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mte_pkg::ST_DELTA) |-> (grp_q < mte_pkg::CntW'(mte_pkg::NumDigits)))
		else $error("delta group index out of range");

endmodule

>>> design/mte_delta_sub.sv
module mte_delta_sub (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mte_pkg::TimeW-1:0]       cur_time,
	input  logic [mte_pkg::TimeW-1:0]       prev_time,
	output logic [mte_pkg::DeltaW-1:0]      delta,
	output mte_pkg::dstat_t                 stat
);

	localparam int PadW = mte_pkg::DeltaW - mte_pkg::TimeW;

	logic [mte_pkg::DeltaW-1:0] a_q, b_q, d_q;
	logic                       borrow_q;
	logic                       busy_q, done_q;
	logic [mte_pkg::CntW-1:0]   cnt_q, groups_q;
	logic [mte_pkg::DigitW:0]   diff;
	logic [mte_pkg::DigitW-1:0] dig;
	logic                       last_dig;

	// one 7-bit digit a cycle, least significant first, borrow rippled through a flop
	assign diff = {1'b0, a_q[mte_pkg::DigitW-1:0]} - {1'b0, b_q[mte_pkg::DigitW-1:0]}
		- {{mte_pkg::DigitW{1'b0}}, borrow_q};
	assign last_dig = (cnt_q == mte_pkg::CntW'(mte_pkg::NumDigits - 1));

	always_comb begin
		dig = diff[mte_pkg::DigitW-1:0];
		// drop borrow bits above bit 31 so the delta wraps mod 2^32
		if (last_dig) begin
			dig = {{(mte_pkg::DigitW - mte_pkg::TopBits){1'b0}}, diff[mte_pkg::TopBits-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			groups_q <= mte_pkg::CntW'(1);
			borrow_q <= 1'b0;
		end else if (start) begin
			busy_q   <= 1'b1;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			groups_q <= mte_pkg::CntW'(1);
			borrow_q <= 1'b0;
		end else if (busy_q) begin
			borrow_q <= diff[mte_pkg::DigitW];
			cnt_q    <= cnt_q + mte_pkg::CntW'(1);
			if (dig != '0) begin
				groups_q <= cnt_q + mte_pkg::CntW'(1);
			end
			if (last_dig) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= {{PadW{1'b0}}, cur_time};
			b_q <= {{PadW{1'b0}}, prev_time};
		end else if (busy_q) begin
			a_q <= a_q >> mte_pkg::DigitW;
			b_q <= b_q >> mte_pkg::DigitW;
			d_q <= {dig, d_q[mte_pkg::DeltaW-1:mte_pkg::DigitW]};
		end
	end

	assign delta       = d_q;
	assign stat.done   = done_q;
	assign stat.groups = groups_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("delta unit busy and done together");
	a_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last_dig && !start) |=> (done_q && !busy_q))
		else $error("delta unit did not finish after last digit");
	a_groups: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (groups_q != '0 && groups_q <= mte_pkg::CntW'(mte_pkg::NumDigits)))
		else $error("group count out of range");

endmodule
